### hw/rtl/bbr_pkg.sv
// shared types, constants and the reciprocal table for the box blur block
// no dependencies
package bbr_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_HALF   = 7;
	localparam int RING_ROWS  = 2 * MAX_HALF + 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SLOT_W     = $clog2(RING_ROWS);
	localparam int ADDR_W     = SLOT_W + COL_W;
	localparam int ACC_W      = 16;
	localparam int RECIP_W    = 25;
	localparam int RECIP_SH   = 24;

	// register byte-address indexes (paddr[3:2])
	localparam logic [1:0] REG_HALF   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic [7:0] channel_0;
		logic [7:0] channel_1;
		logic [7:0] channel_2;
	} pix_t;

	typedef struct packed {
		logic [10:0] out_row;
		logic [10:0] out_col;
		logic [7:0]  out_channel_0;
		logic [7:0]  out_channel_1;
		logic [7:0]  out_channel_2;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic [2:0]  h;
		logic [11:0] w;
		logic [11:0] ht;
	} cfg_t;

	typedef struct packed {
		logic       accept;
		logic       load_border;
		logic       sum_start;
		logic       div_en;
		logic [1:0] div_sel;
		logic       load_blur;
	} dp_cmd_t;

	typedef struct packed {
		logic border;
		logic blur;
		logic sum_done;
		logic out_full;
	} dp_stat_t;

	// ceil(2^24 / area) for each radius; exact for every window sum
	function automatic logic [RECIP_W-1:0] recip(input logic [2:0] h);
		logic [RECIP_W-1:0] m;
		case (h)
			3'd0:    m = 25'd16777216;
			3'd1:    m = 25'd1864136;
			3'd2:    m = 25'd671089;
			3'd3:    m = 25'd342393;
			3'd4:    m = 25'd207127;
			3'd5:    m = 25'd138655;
			3'd6:    m = 25'd99274;
			default: m = 25'd74566;
		endcase
		return m;
	endfunction

endpackage

### hw/rtl/bbr_datapath.sv
// line store, position counters, window accumulator, divider and result register
// depends on bbr_pkg
module bbr_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  bbr_pkg::cfg_t   cfg,
	input  bbr_pkg::dp_cmd_t cmd,
	output bbr_pkg::dp_stat_t stat,
	input  bbr_pkg::pix_t   pix,
	output bbr_pkg::res_t   res,
	output logic            res_valid,
	input  logic            res_stall
);
	import bbr_pkg::*;

	logic [23:0] mem [0:RING_ROWS*MAX_WIDTH-1];

	logic [COL_W-1:0]  col_q, cur_col_q, dx_q, c0, col_n;
	logic [ROW_W-1:0]  row_q, cur_row_q, r0, row_n;
	logic [SLOT_W-1:0] slot_q, cur_slot_q, s0, s_a, slot_n, dy_q, rs;
	logic [11:0]       r_a, c1, r1;
	logic              col_wrap, row_wrap, end_row, end_frame;
	pix_t              px_q;
	logic [3:0]        side_m1;
	logic              run_q, rd_v_s1, last_issue;
	logic [23:0]       rdata_s1;
	logic [ACC_W-1:0]  acc0_q, acc1_q, acc2_q, div_x;
	logic [7:0]        q0_q, q1_q, q2_q;
	logic [ACC_W+RECIP_W-1:0] prod;
	logic [4:0]        rs_w;
	res_t              out_q;
	logic              out_valid_q;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(RING_ROWS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	// position of the arriving pixel, then of the next one
	always_comb begin
		col_wrap  = {1'b0, col_q} >= cfg.w;
		r_a       = col_wrap ? {1'b0, row_q} + 12'd1 : {1'b0, row_q};
		s_a       = col_wrap ? slot_inc(slot_q) : slot_q;
		row_wrap  = r_a >= cfg.ht;
		r0        = row_wrap ? '0 : r_a[ROW_W-1:0];
		s0        = row_wrap ? '0 : s_a;
		c0        = col_wrap ? '0 : col_q;
		c1        = {1'b0, c0} + 12'd1;
		r1        = {1'b0, r0} + 12'd1;
		end_row   = c1 >= cfg.w;
		end_frame = end_row && (r1 >= cfg.ht);
		col_n     = end_row ? '0 : c1[COL_W-1:0];
		row_n     = end_row ? (end_frame ? '0 : r1[ROW_W-1:0]) : r0;
		slot_n    = end_row ? (end_frame ? '0 : slot_inc(s0)) : s0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (cmd.accept) begin
			col_q  <= col_n;
			row_q  <= row_n;
			slot_q <= slot_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_col_q  <= c0;
			cur_row_q  <= r0;
			cur_slot_q <= s0;
			px_q       <= pix;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			mem[{s0, c0}] <= {pix.channel_2, pix.channel_1, pix.channel_0};
	end

	always_comb begin
		stat.border = ({1'b0, cur_row_q} < {9'd0, cfg.h}) ||
		              (cur_col_q < {8'd0, cfg.h}) ||
		              ({1'b0, cur_row_q} + {9'd0, cfg.h} >= cfg.ht) ||
		              ({1'b0, cur_col_q} + {9'd0, cfg.h} >= cfg.w);
		stat.blur   = (cur_row_q >= {7'd0, cfg.h, 1'b0}) &&
		              (cur_col_q >= {7'd0, cfg.h, 1'b0});
		stat.sum_done = !run_q && !rd_v_s1;
		stat.out_full = out_valid_q;
	end

	// window walk: dy over rows of the ring, dx back along the row
	always_comb begin
		side_m1    = {cfg.h, 1'b0};
		last_issue = (dy_q == side_m1) && (dx_q[3:0] == side_m1);
		rs_w       = (dy_q > cur_slot_q) ?
		             {1'b0, cur_slot_q} + 5'(RING_ROWS) - {1'b0, dy_q} :
		             {1'b0, cur_slot_q} - {1'b0, dy_q};
		rs         = rs_w[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= run_q;
			if (cmd.sum_start)
				run_q <= 1'b1;
			else if (run_q && last_issue)
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_start) begin
			dy_q <= '0;
			dx_q <= '0;
		end else if (run_q) begin
			if (dx_q[3:0] == side_m1) begin
				dx_q <= '0;
				dy_q <= dy_q + SLOT_W'(1);
			end else begin
				dx_q <= dx_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q)
			rdata_s1 <= mem[{rs, cur_col_q - dx_q}];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_start) begin
			acc0_q <= '0;
			acc1_q <= '0;
			acc2_q <= '0;
		end else if (rd_v_s1) begin
			acc0_q <= acc0_q + {8'd0, rdata_s1[7:0]};
			acc1_q <= acc1_q + {8'd0, rdata_s1[15:8]};
			acc2_q <= acc2_q + {8'd0, rdata_s1[23:16]};
		end
	end

	// one channel per cycle through the shared reciprocal multiplier
	always_comb begin
		case (cmd.div_sel)
			2'd0:    div_x = acc0_q;
			2'd1:    div_x = acc1_q;
			default: div_x = acc2_q;
		endcase
		prod = {{RECIP_W{1'b0}}, div_x} * {{ACC_W{1'b0}}, recip(cfg.h)};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_en) begin
			case (cmd.div_sel)
				2'd0:    q0_q <= prod[RECIP_SH+7:RECIP_SH];
				2'd1:    q1_q <= prod[RECIP_SH+7:RECIP_SH];
				default: q2_q <= prod[RECIP_SH+7:RECIP_SH];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_border || cmd.load_blur)
			out_valid_q <= 1'b1;
		else if (!res_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_border) begin
			out_q.out_row       <= cur_row_q;
			out_q.out_col       <= cur_col_q;
			out_q.out_channel_0 <= px_q.channel_0;
			out_q.out_channel_1 <= px_q.channel_1;
			out_q.out_channel_2 <= px_q.channel_2;
			out_q.last_of_run   <= !stat.blur;
		end else if (cmd.load_blur) begin
			out_q.out_row       <= cur_row_q - {8'd0, cfg.h};
			out_q.out_col       <= cur_col_q - {8'd0, cfg.h};
			out_q.out_channel_0 <= q0_q;
			out_q.out_channel_1 <= q1_q;
			out_q.out_channel_2 <= q2_q;
			out_q.last_of_run   <= 1'b1;
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

endmodule

### hw/rtl/bbr_ctrl.sv
// sequencer for one pixel: accept, border copy, window sum, divide, blurred result
// depends on bbr_pkg
module bbr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  bbr_pkg::dp_stat_t stat,
	output bbr_pkg::dp_cmd_t  cmd
);
	import bbr_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_SUM    = 7'b0000100,
		ST_DIV0   = 7'b0001000,
		ST_DIV1   = 7'b0010000,
		ST_DIV2   = 7'b0100000,
		ST_BLUR   = 7'b1000000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					cmd.accept = 1'b1;
					state_n    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.border) begin
					if (!stat.out_full) begin
						cmd.load_border = 1'b1;
						cmd.sum_start   = stat.blur;
						state_n         = stat.blur ? ST_SUM : ST_IDLE;
					end
				end else if (stat.blur) begin
					cmd.sum_start = 1'b1;
					state_n       = ST_SUM;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_SUM: begin
				if (stat.sum_done)
					state_n = ST_DIV0;
			end
			ST_DIV0: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = 2'd0;
				state_n     = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = 2'd1;
				state_n     = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = 2'd2;
				state_n     = ST_BLUR;
			end
			ST_BLUR: begin
				if (!stat.out_full) begin
					cmd.load_blur = 1'b1;
					state_n       = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	assign pix_stall = (state_q != ST_IDLE);

endmodule

### hw/rtl/box_blur_rgb.sv
// top level of the rgb box blur: register port, controller and datapath
// depends on bbr_pkg, bbr_ctrl, bbr_datapath
//
// Streaming (2h+1)x(2h+1) mean filter over 8-bit three-channel pixels in raster
// order. One pixel is taken at a time. A pixel with no blurred result passes
// through the accept and decide states plus any wait on the result side; a
// pixel that completes a window also walks that window through the single read port
// of the line store, one pixel per cycle, then a reciprocal multiply for each of
// the three channels in turn. Border pixels come out unchanged, before the
// blurred pixel of the same request. Registers: half_width at 0x0, image_width
// at 0x4, image_height at 0x8; write them only while the block is idle. The
// line store needs no clearing after reset.
module box_blur_rgb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          pix_valid,
	output logic          pix_stall,
	input  bbr_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_stall,
	output bbr_pkg::res_t res
);
	import bbr_pkg::*;

	logic [2:0]  half_q;
	logic [11:0] width_q, height_q;
	cfg_t        cfg;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 3'd1;
			width_q  <= 12'd640;
			height_q <= 12'd480;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_HALF:   half_q   <= pwdata[2:0];
				REG_WIDTH:  width_q  <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HALF:   prdata = {29'd0, half_q};
			REG_WIDTH:  prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {20'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	// zero dimension counts as one, oversize as the maximum
	always_comb begin
		cfg.h  = half_q;
		cfg.w  = (width_q == '0) ? 12'd1 :
		         (width_q > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_q;
		cfg.ht = (height_q == '0) ? 12'd1 :
		         (height_q > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : height_q;
	end

	bbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bbr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.pix       (pix),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

### dv/tb_box_blur_rgb.sv
// self-checking testbench for box_blur_rgb: random frames, a line-buffer predictor, apb setup
// depends on bbr_pkg and box_blur_rgb
`timescale 1ns / 1ps

module tb_box_blur_rgb;
	import bbr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	pix_t        pix = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;

	box_blur_rgb dut (.*);

	always #5 clk = ~clk;

	pix_t pending_pix[$];
	res_t expected_res[$];
	int   mismatches = 0;
	bit   calm = 1'b0;
	int   send_gap = 0;
	int   recv_gap = 0;

	// blur state: mirrors the frame position and the last rows of pixels
	logic [2:0]  blur_half = 3'd1;
	logic [11:0] frame_w = 12'd640;
	logic [11:0] frame_h = 12'd480;
	pix_t        rows_seen[RING_ROWS][MAX_WIDTH];
	int          cur_row = 0;
	int          cur_col = 0;

	function automatic int clamp_dim(input logic [11:0] v, input int maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : int'(v);
	endfunction

	function automatic void predict_blur(input pix_t p);
		int h, w, ht, side, area, s0, s1, s2, rs;
		bit border, blur;
		res_t r;
		h = (blur_half > MAX_HALF) ? MAX_HALF : int'(blur_half);
		w = clamp_dim(frame_w, MAX_WIDTH);
		ht = clamp_dim(frame_h, MAX_HEIGHT);
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= ht) cur_row = 0;
		rows_seen[cur_row % RING_ROWS][cur_col] = p;
		border = (cur_row < h) || (cur_col < h) || (cur_row + h >= ht) || (cur_col + h >= w);
		blur = (cur_row >= 2 * h) && (cur_col >= 2 * h);
		if (border) begin
			r.out_row = cur_row[10:0];
			r.out_col = cur_col[10:0];
			r.out_channel_0 = p.channel_0;
			r.out_channel_1 = p.channel_1;
			r.out_channel_2 = p.channel_2;
			r.last_of_run = !blur;
			expected_res = {expected_res, r};
		end
		if (blur) begin
			side = 2 * h + 1;
			area = side * side;
			s0 = 0;
			s1 = 0;
			s2 = 0;
			for (int dy = 0; dy < side; dy++) begin
				rs = (cur_row + RING_ROWS - dy) % RING_ROWS;
				for (int dx = 0; dx < side; dx++) begin
					s0 += rows_seen[rs][cur_col - dx].channel_0;
					s1 += rows_seen[rs][cur_col - dx].channel_1;
					s2 += rows_seen[rs][cur_col - dx].channel_2;
				end
			end
			r.out_row = 11'(cur_row - h);
			r.out_col = 11'(cur_col - h);
			r.out_channel_0 = 8'(s0 / area);
			r.out_channel_1 = 8'(s1 / area);
			r.out_channel_2 = 8'(s2 / area);
			r.last_of_run = 1'b1;
			expected_res = {expected_res, r};
		end
		cur_col++;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= ht) cur_row = 0;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall) predict_blur(pix);
			if (!pix_valid || !pix_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					pix_valid <= 1'b0;
				end else if (pending_pix.size() > 0) begin
					pix <= pending_pix.pop_front();
					pix_valid <= 1'b1;
					if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result row %0d col %0d", res.out_row, res.out_col);
				end else begin
					res_t want;
					want = expected_res.pop_front();
					if (res.out_row !== want.out_row || res.out_col !== want.out_col ||
					    res.out_channel_0 !== want.out_channel_0 ||
					    res.out_channel_1 !== want.out_channel_1 ||
					    res.out_channel_2 !== want.out_channel_2 ||
					    res.last_of_run !== want.last_of_run) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp r%0d c%0d %h %h %h l%0b got r%0d c%0d %h %h %h l%0b",
								want.out_row, want.out_col, want.out_channel_0,
								want.out_channel_1, want.out_channel_2, want.last_of_run,
								res.out_row, res.out_col, res.out_channel_0,
								res.out_channel_1, res.out_channel_2, res.last_of_run);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				res_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				recv_gap <= $urandom_range(0, 12);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {20'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HALF:   blur_half = val[2:0];
			REG_WIDTH:  frame_w = val;
			REG_HEIGHT: frame_h = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_pix.size() > 0 || pix_valid || expected_res.size() > 0)
			@(posedge clk);
		// let the last request settle before the registers change
		repeat (300) @(posedge clk);
	endtask

	// runs one whole frame so the counters are back at the origin afterwards
	task automatic run_frame(input logic [2:0] h, input logic [11:0] w, input logic [11:0] ht,
			input int pattern);
		int n;
		pix_t p;
		wait_idle();
		write_reg(REG_HALF, {9'd0, h});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, ht);
		n = clamp_dim(w, MAX_WIDTH) * clamp_dim(ht, MAX_HEIGHT);
		for (int k = 0; k < n; k++) begin
			case (pattern)
				0: p = '1;
				1: p = {(k % 2) ? 8'hff : 8'h00, (k % 3) ? 8'h00 : 8'hff, (k % 4 < 2) ? 8'hff : 8'h00};
				default: begin
					p = pix_t'(24'($urandom));
					if ($urandom_range(0, 15) == 0) p.channel_1 = $urandom_range(0, 1) ? 8'hff : 8'h00;
				end
			endcase
			pending_pix = {pending_pix, p};
		end
	endtask

	initial begin
		int sent;
		int h;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed frames: saturated, alternating extremes, unit kernel, zero sizes
		run_frame(3'd1, 12'd3, 12'd3, 0);
		run_frame(3'd1, 12'd3, 12'd3, 1);
		run_frame(3'd0, 12'd2, 12'd2, 2);
		run_frame(3'd3, 12'd0, 12'd0, 2);
		sent = 0;
		while (sent < 1200) begin
			int w, ht;
			h = $urandom_range(0, 7);
			if ($urandom_range(0, 5) == 0) begin
				w = $urandom_range(1, 2 * h + 1);
				ht = $urandom_range(1, 2 * h + 2);
			end else begin
				w = 2 * h + 1 + $urandom_range(0, 6);
				ht = 2 * h + 1 + $urandom_range(0, 5);
			end
			if (sent > 950) calm = 1'b1;
			run_frame(h[2:0], w[11:0], ht[11:0], 2);
			sent += w * ht;
		end
		wait_idle();
		if (mismatches == 0 && expected_res.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
